### src/sha256inc_pkg.sv
package sha256inc_pkg;

  // Action codes of an input beat.
  localparam logic [1:0] ActAbsorb  = 2'd0;
  localparam logic [1:0] ActFinish  = 2'd1;
  localparam logic [1:0] ActRestart = 2'd2;

  // Status codes of a result beat.
  localparam logic [1:0] StatDigest   = 2'd0;
  localparam logic [1:0] StatDone     = 2'd1;
  localparam logic [1:0] StatOverflow = 2'd2;

  localparam int unsigned LenWidth = 61;
  localparam logic [LenWidth-1:0] MaxLenReset = {LenWidth{1'b1}};

  // Byte position in the block at which the 64-bit length field starts.
  localparam logic [5:0] LenFieldPos = 6'd56;
  localparam logic [7:0] PadByte     = 8'h80;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Commands from the sequencer to the compression core.
  typedef struct packed {
    logic       push;       // shift one message byte into the block window
    logic [7:0] push_byte;
    logic       start;      // begin a 64-round compression of the window
    logic       init;       // load the initial hash values
  } core_ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] xx;
    xx = {x, x} >> n;
    return xx[31:0];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
  endfunction

endpackage

### src/sha256_incremental_hash.sv
// Channel   Handshake                    Payload
// in        in_valid_i / in_ready_o      action_i, data_byte_i
// out       out_valid_o / out_ready_i    status_o, digest_word_o, word_index_o, last_o
// cfg       cfg_valid_i / cfg_ready_o    max_message_bytes_i
//
// An absorb beat that does not complete a block leaves the sequencer idle, so
// bytes may follow back to back. The byte that fills the 64-byte block starts
// the shared round unit, which runs 64 rounds and then folds the result into the
// hash, and the input is held off until it is done. A finish beat pushes the pad
// bytes one per cycle, pausing while a filled block is compressed, runs one or
// two compressions and then offers eight digest beats, each held until the
// output takes it. Reset is asynchronous and active low; the block needs no
// clearing pass. The configuration port is always ready.
module sha256_incremental_hash (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input beats.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic [7:0]                          data_byte_i,
  // Result beats.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [31:0]                         digest_word_o,
  output logic [2:0]                          word_index_o,
  output logic                                last_o,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sha256inc_pkg::LenWidth-1:0]  max_message_bytes_i
);
  import sha256inc_pkg::*;

  // The sequencer. Padding is done by feeding the pad, zero and length bytes
  // through the same byte path as message data, one per cycle except while a block filled during padding is compressed.
  typedef enum logic [2:0] {
    ST_IDLE,     // waiting for an input beat
    ST_COMP,     // compression of a block filled by an absorb
    ST_PAD80,    // push the 0x80 pad byte
    ST_PADZ,     // push zero fill until the length field is reached
    ST_PADWAIT,  // compression of a block filled by the pad or zero fill bytes
    ST_PADL,     // push the eight bytes of the bit length, most significant first
    ST_FINAL,    // compression of the last block
    ST_EMIT      // hand out the eight digest words
  } seq_state_e;

  seq_state_e            state_q, state_d;
  logic [5:0]            count_q, count_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [LenWidth-1:0]   max_q, max_d;
  logic                  done_q, done_d;
  logic [2:0]            widx_q, widx_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            status_q, status_d;
  logic [31:0]           word_q, word_d;
  logic [2:0]            index_q, index_d;
  logic                  last_q, last_d;

  core_ctrl_t            ctrl;
  logic                  core_busy;
  logic [7:0][31:0]      hash;

  logic                  in_accept;
  logic                  out_free;
  logic [5:0]            count_inc;
  logic [63:0]           bit_len;
  logic [5:0]            len_base;

  sha256inc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .busy_o (core_busy),
    .hash_o (hash)
  );

  // The output register is free when it is empty or its beat leaves now.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign count_inc = count_q + 6'd1;
  assign bit_len   = {len_q, 3'b000};
  // Byte i of the length field sits at bits 63-8i down; ~i is 7-i on three bits.
  assign len_base  = {~count_q[2:0], 3'b000};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    len_d       = len_q;
    max_d       = max_q;
    done_d      = done_q;
    widx_d      = widx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    word_d      = word_q;
    index_d     = index_q;
    last_d      = last_q;
    ctrl        = '0;

    if (cfg_valid_i) begin
      max_d = max_message_bytes_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (action_i)
            ActAbsorb: begin
              if (done_q || (len_q >= max_q)) begin
                // A byte after finish, or one past the length limit, is refused.
                out_valid_d = 1'b1;
                status_d    = done_q ? StatDone : StatOverflow;
                word_d      = '0;
                index_d     = '0;
                last_d      = 1'b1;
              end else begin
                ctrl.push      = 1'b1;
                ctrl.push_byte = data_byte_i;
                count_d        = count_inc;
                len_d          = len_q + 1'b1;
                if (&count_q) begin
                  ctrl.start = 1'b1;
                  state_d    = ST_COMP;
                end
              end
            end
            ActFinish: begin
              if (done_q) begin
                out_valid_d = 1'b1;
                status_d    = StatDone;
                word_d      = '0;
                index_d     = '0;
                last_d      = 1'b1;
              end else begin
                done_d  = 1'b1;
                state_d = ST_PAD80;
              end
            end
            ActRestart: begin
              ctrl.init = 1'b1;
              count_d   = '0;
              len_d     = '0;
              done_d    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_COMP: begin
        if (!core_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD80, ST_PADZ: begin
        ctrl.push      = 1'b1;
        ctrl.push_byte = (state_q == ST_PAD80) ? PadByte : 8'h00;
        count_d        = count_inc;
        if (count_inc == '0) begin
          ctrl.start = 1'b1;
          state_d    = ST_PADWAIT;
        end else if (count_inc == LenFieldPos) begin
          state_d = ST_PADL;
        end else begin
          state_d = ST_PADZ;
        end
      end
      ST_PADWAIT: begin
        if (!core_busy) begin
          state_d = ST_PADZ;
        end
      end
      ST_PADL: begin
        ctrl.push      = 1'b1;
        ctrl.push_byte = bit_len[len_base +: 8];
        count_d        = count_inc;
        if (count_inc == '0) begin
          ctrl.start = 1'b1;
          state_d    = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!core_busy) begin
          widx_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = StatDigest;
          word_d      = hash[widx_q];
          index_d     = widx_q;
          last_d      = &widx_q;
          widx_d      = widx_q + 3'd1;
          if (&widx_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      len_q       <= '0;
      max_q       <= MaxLenReset;
      done_q      <= 1'b0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StatDigest;
      word_q      <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      len_q       <= len_d;
      max_q       <= max_d;
      done_q      <= done_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      word_q      <= word_d;
      index_q     <= index_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign digest_word_o = word_q;
  assign word_index_o  = index_q;
  assign last_o        = last_q;

endmodule

### src/sha256inc_core.sv
module sha256inc_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sha256inc_pkg::core_ctrl_t ctrl_i,
  output logic                      busy_o,
  output logic [7:0][31:0]          hash_o
);
  import sha256inc_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD
  } core_state_e;

  core_state_e     state_q;
  logic [5:0]      rnd_q;
  logic [7:0][31:0] hash_q;
  logic [7:0][31:0] v_q;
  logic [7:0][31:0] v_d;
  // The window holds the sixteen schedule words w[t..t+15], w[t] at the top.
  logic [511:0]    win_q;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] ch, maj, t1, t2;

  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];
  assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + RoundK[rnd_q] + w0;
  assign t2  = big_sigma0(v_q[0]) + maj;

  always_comb begin
    v_d[0] = t1 + t2;
    v_d[1] = v_q[0];
    v_d[2] = v_q[1];
    v_d[3] = v_q[2];
    v_d[4] = v_q[3] + t1;
    v_d[5] = v_q[4];
    v_d[6] = v_q[5];
    v_d[7] = v_q[6];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      win_q <= {win_q[503:0], ctrl_i.push_byte};
    end else if (state_q == C_ROUND) begin
      win_q <= {win_q[479:0], w_new};
    end
    if (ctrl_i.start) begin
      v_q <= hash_q;
    end else if (state_q == C_ROUND) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= InitHash[i];
      end
    end else begin
      unique case (state_q)
        C_IDLE: begin
          if (ctrl_i.init) begin
            for (int i = 0; i < 8; i++) begin
              hash_q[i] <= InitHash[i];
            end
          end
          if (ctrl_i.start) begin
            state_q <= C_ROUND;
            rnd_q   <= '0;
          end
        end
        C_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (&rnd_q) begin
            state_q <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + v_q[i];
          end
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != C_IDLE);
  assign hash_o = hash_q;

endmodule

### test/sha256_incremental_hash_tb.sv
`timescale 1ns / 1ps

module sha256_incremental_hash_tb;

  localparam int unsigned LW = sha256inc_pkg::LenWidth;

  // One beat offered on the input channel.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data;
  } hash_cmd_t;

  // One beat expected on the result channel.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } hash_beat_t;

  // Ports of the block. Every input starts at a known value.
  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [1:0]    action_i = sha256inc_pkg::ActAbsorb;
  logic [7:0]    data_byte_i = 8'h00;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [1:0]    status_o;
  logic [31:0]   digest_word_o;
  logic [2:0]    word_index_o;
  logic          last_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [LW-1:0] max_message_bytes_i = sha256inc_pkg::MaxLenReset;

  // Stimulus and scoreboard bookkeeping.
  hash_cmd_t  cmd_q[$];
  hash_beat_t due_results[$];
  hash_cmd_t  tx_cmd = '0;
  bit         tx_busy = 1'b0;
  int         issued = 0;
  int         taken = 0;
  int         tx_idle_pct = 35;
  int         rx_idle_pct = 68;
  bit         stall_req = 1'b0;
  logic       rx_hold = 1'b0;
  int         mismatches = 0;
  int         beats_seen = 0;
  int         digests_done = 0;
  int         error_beats = 0;
  int         compressions = 0;
  int         cfg_writes = 0;

  // Predicted engine state, kept alongside the block.
  logic [31:0]   hash_h [8];
  logic [7:0]    blk_bytes [64];
  logic [5:0]    fill;
  logic [LW-1:0] msg_len;
  bit            sealed;
  logic [LW-1:0] lim_bytes;

  sha256_incremental_hash uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .digest_word_o       (digest_word_o),
    .word_index_o        (word_index_o),
    .last_o              (last_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .max_message_bytes_i (max_message_bytes_i)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // SHA-256 arithmetic for the predictor.
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] cap_sigma0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] cap_sigma1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] low_sigma0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] low_sigma1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  // Runs the 64 rounds over the current block and folds the result into the
  // running hash words.
  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + low_sigma0(w[i-15]) + w[i-7] + low_sigma1(w[i-2]);
    end
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + cap_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
           sha256inc_pkg::RoundK[i] + w[i];
      t2 = cap_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
    compressions++;
  endfunction

  // Restart returns the hash state to its initial values; the limit register
  // is not touched.
  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) hash_h[i] = sha256inc_pkg::InitHash[i];
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    fill    = '0;
    msg_len = '0;
    sealed  = 1'b0;
  endfunction

  function automatic void push_error(input logic [1:0] code);
    hash_beat_t b;
    b.status = code;
    b.word   = '0;
    b.index  = '0;
    b.last   = 1'b1;
    due_results = {due_results, b};
  endfunction

  // Applies one accepted input beat to the predicted state and queues the
  // result beats it causes.
  function automatic void hash_step(input hash_cmd_t cmd);
    int          pos;
    logic [63:0] bit_len;
    hash_beat_t  b;
    case (cmd.action)
      sha256inc_pkg::ActAbsorb: begin
        if (sealed) begin
          push_error(sha256inc_pkg::StatDone);
        end else if (msg_len >= lim_bytes) begin
          // The byte is refused and nothing else changes.
          push_error(sha256inc_pkg::StatOverflow);
        end else begin
          blk_bytes[fill] = cmd.data;
          fill    = fill + 6'd1;
          msg_len = msg_len + 1'b1;
          if (fill == 6'd0) sha_compress();
        end
      end
      sha256inc_pkg::ActFinish: begin
        if (sealed) begin
          push_error(sha256inc_pkg::StatDone);
        end else begin
          sealed  = 1'b1;
          bit_len = {msg_len, 3'b000};
          pos = int'(fill);
          blk_bytes[pos] = sha256inc_pkg::PadByte;
          pos++;
          // No room left for the length field: pad out and compress an extra
          // block first.
          if (pos > int'(sha256inc_pkg::LenFieldPos)) begin
            while (pos < 64) begin
              blk_bytes[pos] = 8'h00;
              pos++;
            end
            sha_compress();
            pos = 0;
          end
          while (pos < int'(sha256inc_pkg::LenFieldPos)) begin
            blk_bytes[pos] = 8'h00;
            pos++;
          end
          for (int i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
          sha_compress();
          fill = '0;
          for (int i = 0; i < 8; i++) begin
            b.status = sha256inc_pkg::StatDigest;
            b.word   = hash_h[i];
            b.index  = 3'(i);
            b.last   = (i == 7);
            due_results = {due_results, b};
          end
        end
      end
      sha256inc_pkg::ActRestart: hash_restart();
      default: ;  // the unused code is ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. An accepted beat is handed to the predictor at the edge on
  // which it is taken; the next pending beat may follow at once, so valid
  // stays high without being lowered in between.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tx_busy && in_ready_o) begin
        hash_step(tx_cmd);
        taken++;
        tx_busy = 1'b0;
      end
      if (!tx_busy && cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tx_cmd  = cmd_q.pop_front();
        tx_busy = 1'b1;
      end
      in_valid_i  <= tx_busy;
      action_i    <= tx_cmd.action;
      data_byte_i <= tx_cmd.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Each accepted beat is compared with the oldest expected
  // one. Ready is dropped at random, and held low throughout a long stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hash_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        beats_seen++;
        if (status_o != sha256inc_pkg::StatDigest) error_beats++;
        if (status_o == sha256inc_pkg::StatDigest && last_o) digests_done++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat status %0d word %08h index %0d last %0b",
                                    status_o, digest_word_o, word_index_o, last_o));
        end else begin
          want = due_results.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (digest_word_o !== want.word)
            report_mismatch($sformatf("word %08h, expected %08h", digest_word_o, want.word));
          if (word_index_o !== want.index)
            report_mismatch($sformatf("index %0d, expected %0d", word_index_o, want.index));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last_o, want.last));
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver stall: ready stays low while the sender keeps offering beats,
  // so the result path backs up and the input is held off.
  always begin
    wait (stall_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
    stall_req = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  task automatic queue_cmd(input logic [1:0] act, input logic [7:0] data);
    hash_cmd_t c;
    c.action = act;
    c.data   = data;
    cmd_q = {cmd_q, c};
    issued++;
  endtask

  // Restart, a run of random bytes and, unless the message is abandoned, a
  // finish.
  task automatic queue_message(input int len, input bit with_finish);
    queue_cmd(sha256inc_pkg::ActRestart, 8'($urandom));
    for (int i = 0; i < len; i++) queue_cmd(sha256inc_pkg::ActAbsorb, 8'($urandom));
    if (with_finish) queue_cmd(sha256inc_pkg::ActFinish, 8'($urandom));
  endtask

  // Mostly well-formed messages, with lengths bunched around the points where
  // padding spills into a second block, plus some noise and abandoned ones.
  task automatic queue_random_traffic(input int upto);
    int pick;
    int len;
    while (issued < upto) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(8);
      end else if (pick < 80) begin
        case ($urandom_range(5))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          default: len = 119 + $urandom_range(2);
        endcase
      end else begin
        len = $urandom_range(70, 9);
      end
      queue_message(len, $urandom_range(99) >= 15);
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(3, 1)) queue_cmd(2'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  // Waits until every queued beat has been taken and every expected result
  // has come back.
  task automatic drain_all();
    @(negedge clk_i);
    while (cmd_q.size() != 0 || taken != issued || due_results.size() != 0)
      @(negedge clk_i);
  endtask

  // The limit is written only with the block idle. A block-filling byte causes
  // no result but keeps the round unit busy after it is taken, so a margin
  // follows the drain.
  task automatic write_max_len(input logic [LW-1:0] value);
    drain_all();
    repeat (100) @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    max_message_bytes_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lim_bytes = value;
    cfg_writes++;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    hash_restart();
    lim_bytes = sha256inc_pkg::MaxLenReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset limit: the empty message, finishing twice,
    // absorbing after finish, the unused action, a short text and the byte
    // extremes.
    @(negedge clk_i);
    queue_cmd(sha256inc_pkg::ActFinish, 8'h00);
    queue_cmd(sha256inc_pkg::ActFinish, 8'hff);
    queue_cmd(sha256inc_pkg::ActAbsorb, 8'hff);
    queue_cmd(2'd3, 8'hff);
    queue_cmd(sha256inc_pkg::ActRestart, 8'h00);
    queue_cmd(sha256inc_pkg::ActAbsorb, 8'h61);
    queue_cmd(sha256inc_pkg::ActAbsorb, 8'h62);
    queue_cmd(sha256inc_pkg::ActAbsorb, 8'h63);
    queue_cmd(sha256inc_pkg::ActFinish, 8'h00);
    queue_cmd(sha256inc_pkg::ActRestart, 8'hff);
    queue_cmd(sha256inc_pkg::ActAbsorb, 8'h00);
    queue_cmd(sha256inc_pkg::ActAbsorb, 8'hff);
    queue_cmd(sha256inc_pkg::ActFinish, 8'h00);
    queue_cmd(sha256inc_pkg::ActRestart, 8'h00);

    // A zero limit refuses the very first byte.
    write_max_len('0);
    @(negedge clk_i);
    queue_cmd(sha256inc_pkg::ActAbsorb, 8'h5a);
    queue_cmd(sha256inc_pkg::ActFinish, 8'h00);
    queue_cmd(sha256inc_pkg::ActRestart, 8'h00);

    // The byte that would exceed a limit of two is refused.
    write_max_len(LW'(2));
    @(negedge clk_i);
    repeat (3) queue_cmd(sha256inc_pkg::ActAbsorb, 8'($urandom));
    queue_cmd(sha256inc_pkg::ActFinish, 8'h00);
    queue_cmd(sha256inc_pkg::ActRestart, 8'h00);

    // Lowering the limit below the length already taken.
    write_max_len(sha256inc_pkg::MaxLenReset);
    @(negedge clk_i);
    repeat (5) queue_cmd(sha256inc_pkg::ActAbsorb, 8'($urandom));
    write_max_len(LW'(3));
    @(negedge clk_i);
    queue_cmd(sha256inc_pkg::ActAbsorb, 8'($urandom));
    queue_cmd(sha256inc_pkg::ActFinish, 8'h00);
    queue_cmd(sha256inc_pkg::ActRestart, 8'h00);

    // Random phase one: largest limit, sender idles less than the receiver.
    write_max_len(sha256inc_pkg::MaxLenReset);
    @(negedge clk_i);
    queue_random_traffic(180);

    // Random phase two: a small limit so that long messages overflow; the
    // sender pauses midway until every result is back.
    set_idling(68, 35);
    write_max_len(LW'($urandom_range(90, 40)));
    @(negedge clk_i);
    queue_random_traffic(260);
    drain_all();
    queue_random_traffic(340);

    // Random phase three: a random 61-bit limit, no idling on either side, and
    // a long receiver stall right at the start.
    set_idling(0, 0);
    write_max_len(LW'({$urandom, $urandom}));
    @(negedge clk_i);
    stall_req = 1'b1;
    queue_message(4, 1'b1);
    queue_message(3, 1'b1);
    queue_random_traffic(450);

    drain_all();
    repeat (300) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", due_results.size()));

    $display("Covered %0d input beats and %0d result beats: %0d digests, %0d error beats,",
             taken, beats_seen, digests_done, error_beats);
    $display("%0d block compressions and %0d limit writes, %0d mismatches.",
             compressions, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Timeout with %0d beats outstanding.", due_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
